@@ hw/rtl/tsrc_pkg.sv @@
package tsrc_pkg;

    localparam int SHADE_BITS     = 4;
    localparam int CODE_BITS      = 3;
    localparam int MODE_BITS      = 2;
    localparam int DUR_BITS       = 24;
    localparam int CFG_BITS       = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int WORD_OUT_BITS  = 24;
    localparam int BUSY_OUT_BITS  = 8;
    localparam int MASK_BITS      = 3;

    localparam logic [CFG_BITS-1:0] MAX_ON_RESET = 24'd60000;
    localparam logic [CFG_BITS-1:0] PULSE_RESET  = 24'd1000;

    typedef enum logic [CODE_BITS-1:0] {
        CMD_UP             = 3'd0,
        CMD_STOP           = 3'd1,
        CMD_DOWN           = 3'd2,
        CMD_SET_UP_LIMIT   = 3'd3,
        CMD_SET_DOWN_LIMIT = 3'd4,
        CMD_RESET_MEMORY   = 3'd5
    } t_command;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ON       = 2'd0,
        MODE_OFF      = 2'd1,
        MODE_PULSE    = 2'd2,
        MODE_EXPLICIT = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_ON = 2'd0,
        CFG_PULSE  = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic                  action;
        logic [SHADE_BITS-1:0] shade_index;
        logic [CODE_BITS-1:0]  command_code;
        logic [MODE_BITS-1:0]  duration_mode;
        logic [DUR_BITS-1:0]   duration_ms;
    } t_cmd;

    typedef struct packed {
        logic [CFG_BITS-1:0] max_on_ms;
        logic [CFG_BITS-1:0] pulse_ms;
    } t_cfg;

    // Relay bits selected by a command: bit 0 up, bit 1 stop, bit 2 down.
    function automatic logic [MASK_BITS-1:0] cmd_mask(input logic [CODE_BITS-1:0] code);
        logic [MASK_BITS-1:0] m;
        case (code)
            CMD_UP:             m = 3'b001;
            CMD_STOP:           m = 3'b010;
            CMD_DOWN:           m = 3'b100;
            CMD_SET_UP_LIMIT:   m = 3'b110;
            CMD_SET_DOWN_LIMIT: m = 3'b011;
            CMD_RESET_MEMORY:   m = 3'b111;
            default:            m = 3'b000;
        endcase
        return m;
    endfunction

    function automatic logic cmd_active(input logic [CODE_BITS-1:0] code);
        logic a;
        case (code)
            CMD_UP, CMD_STOP, CMD_DOWN, CMD_SET_UP_LIMIT,
            CMD_SET_DOWN_LIMIT, CMD_RESET_MEMORY: a = 1'b1;
            default:                              a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/tsrc_if.sv @@
interface tsrc_cmd_if
    import tsrc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [SHADE_BITS-1:0] shade_index;
    logic [CODE_BITS-1:0]  command_code;
    logic [MODE_BITS-1:0]  duration_mode;
    logic [DUR_BITS-1:0]   duration_ms;

    modport source (
        output valid, action, shade_index, command_code, duration_mode, duration_ms,
        input  ready
    );
    modport sink (
        input  valid, action, shade_index, command_code, duration_mode, duration_ms,
        output ready
    );
endinterface

interface tsrc_res_if
    import tsrc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [WORD_OUT_BITS-1:0] control_word;
    logic                     changed;
    logic [BUSY_OUT_BITS-1:0] busy_mask;

    modport source (
        output valid, control_word, changed, busy_mask,
        input  ready
    );
    modport sink (
        input  valid, control_word, changed, busy_mask,
        output ready
    );
endinterface

@@ hw/rtl/timed_shade_relay_controller.sv @@
// Channel  Direction  Fields
// i_cmd    in         action, shade_index, command_code, duration_mode, duration_ms
// o_res    out        control_word, changed, busy_mask
// cfg      in         i_cfg_we, i_cfg_index, i_cfg_data (0 max_on_ms, 1 pulse_ms)
//
// An accepted transaction is held in the input register, applied to the relay word
// and timers by the single combinational update stage, and its result is captured
// in the output register. One transaction is taken per cycle while the output is not
// stalled. Reset clears relays, timers, valid flags and loads default durations.
// A stalled output holds its result and the input register holds the next transaction.
module timed_shade_relay_controller
    import tsrc_pkg::*;
#(
    parameter int NUM_SHADES = 8,
    parameter int BITS_EACH  = 3,
    parameter int TIMER_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data,
    tsrc_cmd_if.sink                  i_cmd,
    tsrc_res_if.source                o_res
);

    localparam int WORD_W = NUM_SHADES * BITS_EACH;
    localparam int OUT_W  = (WORD_W < WORD_OUT_BITS) ? WORD_W : WORD_OUT_BITS;
    localparam int BUSY_N = (NUM_SHADES < BUSY_OUT_BITS) ? NUM_SHADES : BUSY_OUT_BITS;

    t_cfg                                  r_cfg;
    logic                                  r_in_valid;
    t_cmd                                  r_in;
    logic [NUM_SHADES-1:0][BITS_EACH-1:0]  r_relay;
    logic [NUM_SHADES-1:0][TIMER_BITS-1:0] r_rem;
    logic                                  r_out_valid;
    logic [WORD_OUT_BITS-1:0]              r_out_word;
    logic                                  r_out_changed;
    logic [BUSY_OUT_BITS-1:0]              r_out_busy;

    logic [NUM_SHADES-1:0][BITS_EACH-1:0]  n_relay;
    logic [NUM_SHADES-1:0][TIMER_BITS-1:0] n_rem;
    logic                                  n_changed;
    logic [WORD_W-1:0]                     n_relay_flat;
    logic [NUM_SHADES-1:0]                 n_busy;
    t_cmd                                  in_cmd;
    logic                                  advance;
    logic                                  in_take;

    assign advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_take = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_in_valid || advance;

    assign in_cmd.action        = i_cmd.action;
    assign in_cmd.shade_index   = i_cmd.shade_index;
    assign in_cmd.command_code  = i_cmd.command_code;
    assign in_cmd.duration_mode = i_cmd.duration_mode;
    assign in_cmd.duration_ms   = i_cmd.duration_ms;

    tsrc_step #(
        .NUM_SHADES (NUM_SHADES),
        .BITS_EACH  (BITS_EACH),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_cmd     (r_in),
        .i_cfg     (r_cfg),
        .i_relay   (r_relay),
        .i_rem     (r_rem),
        .o_relay   (n_relay),
        .o_rem     (n_rem),
        .o_changed (n_changed)
    );

    assign n_relay_flat = n_relay;

    always_comb begin
        for (int i = 0; i < NUM_SHADES; i++) begin
            n_busy[i] = (n_rem[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_on_ms <= MAX_ON_RESET;
            r_cfg.pulse_ms  <= PULSE_RESET;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_relay         <= '0;
            r_rem           <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ON: r_cfg.max_on_ms <= i_cfg_data;
                    CFG_PULSE:  r_cfg.pulse_ms  <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_relay     <= n_relay;
                r_rem       <= n_rem;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_cmd;
        end
        if (advance) begin
            r_out_word    <= WORD_OUT_BITS'(n_relay_flat[OUT_W-1:0]);
            r_out_changed <= n_changed;
            r_out_busy    <= BUSY_OUT_BITS'(n_busy[BUSY_N-1:0]);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.control_word = r_out_word;
    assign o_res.changed      = r_out_changed;
    assign o_res.busy_mask    = r_out_busy;

    a_advance_fills_output : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid
    ) else $error("Processed transaction did not reach the output register.");

    a_held_input_stable : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in)
    ) else $error("Waiting input transaction was lost or altered.");

    a_idle_tick_unchanged : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.action && (r_rem == '0) |=> !o_res.changed
    ) else $error("Tick with no running timer reported a change.");

endmodule

@@ hw/rtl/tsrc_step.sv @@
module tsrc_step
    import tsrc_pkg::*;
#(
    parameter int NUM_SHADES = 8,
    parameter int BITS_EACH  = 3,
    parameter int TIMER_BITS = 24
) (
    input  t_cmd                                        i_cmd,
    input  t_cfg                                        i_cfg,
    input  logic [NUM_SHADES-1:0][BITS_EACH-1:0]        i_relay,
    input  logic [NUM_SHADES-1:0][TIMER_BITS-1:0]       i_rem,
    output logic [NUM_SHADES-1:0][BITS_EACH-1:0]        o_relay,
    output logic [NUM_SHADES-1:0][TIMER_BITS-1:0]       o_rem,
    output logic                                        o_changed
);

    logic [DUR_BITS-1:0]   dur;
    logic [TIMER_BITS-1:0] dur_sat;
    logic                  relay_on;
    logic [BITS_EACH-1:0]  set_bits;
    logic                  cmd_ok;

    always_comb begin
        relay_on = 1'b1;
        case (i_cmd.duration_mode)
            MODE_ON:    dur = i_cfg.max_on_ms;
            MODE_OFF: begin
                dur      = '0;
                relay_on = 1'b0;
            end
            MODE_PULSE: dur = i_cfg.pulse_ms;
            default:    dur = i_cmd.duration_ms;
        endcase
    end

    generate
        if (TIMER_BITS >= DUR_BITS) begin : g_wide_timer
            assign dur_sat = TIMER_BITS'(dur);
        end else begin : g_narrow_timer
            assign dur_sat = (|dur[DUR_BITS-1:TIMER_BITS]) ? '1 : dur[TIMER_BITS-1:0];
        end
    endgenerate

    assign set_bits = relay_on ? BITS_EACH'(cmd_mask(i_cmd.command_code)) : '0;
    assign cmd_ok   = !i_cmd.action && cmd_active(i_cmd.command_code);

    always_comb begin
        o_relay = i_relay;
        o_rem   = i_rem;
        for (int i = 0; i < NUM_SHADES; i++) begin
            if (i_cmd.action) begin
                if (i_rem[i] != '0) begin
                    o_rem[i] = i_rem[i] - TIMER_BITS'(1);
                    if (i_rem[i] == TIMER_BITS'(1)) begin
                        o_relay[i] = '0;
                    end
                end
            end else if (cmd_ok && (i_cmd.shade_index == SHADE_BITS'(i))) begin
                o_relay[i] = set_bits;
                o_rem[i]   = dur_sat;
            end
        end
    end

    assign o_changed = (o_relay != i_relay) || (o_rem != i_rem);

endmodule
